// ----- sv/bpc_pkg.sv -----
// Package for the barometric pressure compensation core.
// Holds field widths, calibration register indexes, region codes and limits.
// No dependencies.
package bpc_pkg;

  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int TEMP_W  = 19;
  localparam int PRESS_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -19'sd1500;

  localparam logic signed [PRESS_W-1:0] PRESS_MAX = 32'sh7fff_ffff;
  localparam logic signed [PRESS_W-1:0] PRESS_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C1 = 3'd0,
    CFG_C2 = 3'd1,
    CFG_C3 = 3'd2,
    CFG_C4 = 3'd3,
    CFG_C5 = 3'd4,
    CFG_C6 = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REGION_NORMAL = 2'd0,
    REGION_LOW    = 2'd1,
    REGION_VLOW   = 2'd2
  } region_t;

endpackage

// ----- sv/bpc_if.sv -----
// Channel interfaces of the barometric pressure compensation core.
// Sample, result and calibration write channels; depends on bpc_pkg.
interface bpc_sample_if import bpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  raw_pressure_sample;
  logic [RAW_W-1:0]  raw_temperature_sample;

  modport source (output valid, raw_pressure_sample, raw_temperature_sample, input ready);
  modport sink   (input valid, raw_pressure_sample, raw_temperature_sample, output ready);
endinterface

interface bpc_result_if import bpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [TEMP_W-1:0]  temperature_centi;
  logic signed [PRESS_W-1:0] pressure_centi;
  logic [1:0]                compensation_region;
  logic                      pressure_saturated;

  modport source (output valid, temperature_centi, pressure_centi, compensation_region,
                  pressure_saturated, input ready);
  modport sink   (input valid, temperature_centi, pressure_centi, compensation_region,
                  pressure_saturated, output ready);
endinterface

interface bpc_cfg_if import bpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CAL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/barometric_pressure_compensation_core.sv -----
// Barometric pressure compensation core: takes one raw pressure and temperature
// conversion pair per cycle and returns one compensated result per pair, as long
// as result.ready does not stall; the nine register stages each hold at most one
// multiplier level (dT products, squared deviations, the 24 by 42 bit pressure
// product split in two halves) and every stage advances on its own, so bubbles
// close up while the output register waits. Calibration writes are taken at any
// time and must only be issued while no sample is in flight. Depends on bpc_pkg
// and the bpc_if interfaces.
module barometric_pressure_compensation_core import bpc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  bpc_cfg_if.sink       cfg,
  bpc_sample_if.sink    sample,
  bpc_result_if.source  result
);

  localparam int NSTG = 9;

  logic [CAL_W-1:0] pressure_sensitivity;
  logic [CAL_W-1:0] pressure_offset;
  logic [CAL_W-1:0] sensitivity_temp_coef;
  logic [CAL_W-1:0] offset_temp_coef;
  logic [CAL_W-1:0] reference_temperature;
  logic [CAL_W-1:0] temperature_slope;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_sensitivity  <= '0;
      pressure_offset       <= '0;
      sensitivity_temp_coef <= '0;
      offset_temp_coef      <= '0;
      reference_temperature <= '0;
      temperature_slope     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_C1:  pressure_sensitivity  <= cfg.data;
        CFG_C2:  pressure_offset       <= cfg.data;
        CFG_C3:  sensitivity_temp_coef <= cfg.data;
        CFG_C4:  offset_temp_coef      <= cfg.data;
        CFG_C5:  reference_temperature <= cfg.data;
        CFG_C6:  temperature_slope     <= cfg.data;
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the next one advances
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || result.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign sample.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= sample.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 0: dT
  logic [RAW_W-1:0]  s0_d1;
  logic signed [24:0] s0_dt;
  logic signed [24:0] dt_next;

  assign dt_next = $signed({1'b0, sample.raw_temperature_sample})
                 - $signed({1'b0, reference_temperature, 8'b0});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_d1 <= sample.raw_pressure_sample;
      s0_dt <= dt_next;
    end
  end

  // stage 1: products of dT
  logic [RAW_W-1:0]   s1_d1;
  logic signed [41:0] s1_dt_c6;
  logic signed [49:0] s1_dt_sq;
  logic signed [41:0] s1_c4dt;
  logic signed [41:0] s1_c3dt;
  logic signed [41:0] dt_c6_next;
  logic signed [49:0] dt_sq_next;
  logic signed [41:0] c4dt_next;
  logic signed [41:0] c3dt_next;

  assign dt_c6_next = s0_dt * $signed({1'b0, temperature_slope});
  assign dt_sq_next = s0_dt * s0_dt;
  assign c4dt_next  = s0_dt * $signed({1'b0, offset_temp_coef});
  assign c3dt_next  = s0_dt * $signed({1'b0, sensitivity_temp_coef});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_d1    <= s0_d1;
      s1_dt_c6 <= dt_c6_next;
      s1_dt_sq <= dt_sq_next;
      s1_c4dt  <= c4dt_next;
      s1_c3dt  <= c3dt_next;
    end
  end

  // stage 2: first-order temperature, region, base offset and sensitivity
  logic [RAW_W-1:0]         s2_d1;
  logic signed [TEMP_W-1:0] s2_temp;
  logic [17:0]              s2_t2;
  logic signed [TEMP_W-1:0] s2_dev;
  logic signed [TEMP_W-1:0] s2_lo;
  region_t                  s2_region;
  logic signed [35:0]       s2_off_base;
  logic signed [35:0]       s2_sens_base;
  logic signed [TEMP_W-1:0] temp_next;
  logic                     is_low;
  logic                     is_vlow;
  logic signed [34:0]       c4_sh;
  logic signed [33:0]       c3_sh;
  logic signed [35:0]       off_base_next;
  logic signed [35:0]       sens_base_next;

  assign temp_next = $signed(s1_dt_c6[41:23]) + TEMP_REF;
  assign is_low    = temp_next < TEMP_REF;
  assign is_vlow   = temp_next < TEMP_VLOW;
  assign c4_sh     = s1_c4dt[41:7];
  assign c3_sh     = s1_c3dt[41:8];
  assign off_base_next  = $signed({4'b0, pressure_offset, 16'b0}) + 36'(c4_sh);
  assign sens_base_next = $signed({5'b0, pressure_sensitivity, 15'b0}) + 36'(c3_sh);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_d1        <= s1_d1;
      s2_temp      <= temp_next;
      s2_t2        <= is_low ? s1_dt_sq[48:31] : '0;
      s2_dev       <= is_low ? temp_next - TEMP_REF : '0;
      s2_lo        <= is_vlow ? temp_next - TEMP_VLOW : '0;
      s2_region    <= is_vlow ? REGION_VLOW : (is_low ? REGION_LOW : REGION_NORMAL);
      s2_off_base  <= off_base_next;
      s2_sens_base <= sens_base_next;
    end
  end

  // stage 3: squares of the deviations, final temperature
  logic [RAW_W-1:0]         s3_d1;
  logic signed [TEMP_W-1:0] s3_temp;
  region_t                  s3_region;
  logic signed [35:0]       s3_off_base;
  logic signed [35:0]       s3_sens_base;
  logic [37:0]              s3_sq;
  logic [37:0]              s3_lsq;
  logic signed [37:0]       sq_next;
  logic signed [37:0]       lsq_next;

  assign sq_next  = s2_dev * s2_dev;
  assign lsq_next = s2_lo * s2_lo;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_d1        <= s2_d1;
      s3_temp      <= s2_temp - $signed({1'b0, s2_t2});
      s3_region    <= s2_region;
      s3_off_base  <= s2_off_base;
      s3_sens_base <= s2_sens_base;
      s3_sq        <= sq_next;
      s3_lsq       <= lsq_next;
    end
  end

  // stage 4: second-order offset and sensitivity corrections
  logic [RAW_W-1:0]         s4_d1;
  logic signed [TEMP_W-1:0] s4_temp;
  region_t                  s4_region;
  logic signed [35:0]       s4_off_base;
  logic signed [35:0]       s4_sens_base;
  logic [40:0]              s4_corr_off;
  logic [40:0]              s4_corr_sens;
  logic [39:0]              sq5;
  logic [40:0]              lsq7;
  logic [36:0]              lsq_half;
  logic [40:0]              lh11;

  assign sq5      = {s3_sq, 2'b0} + {2'b0, s3_sq};
  assign lsq7     = {s3_lsq, 3'b0} - {3'b0, s3_lsq};
  assign lsq_half = s3_lsq[37:1];
  assign lh11     = {1'b0, lsq_half, 3'b0} + {3'b0, lsq_half, 1'b0} + {4'b0, lsq_half};

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_d1        <= s3_d1;
      s4_temp      <= s3_temp;
      s4_region    <= s3_region;
      s4_off_base  <= s3_off_base;
      s4_sens_base <= s3_sens_base;
      s4_corr_off  <= {2'b0, sq5[39:1]} + lsq7;
      s4_corr_sens <= {3'b0, sq5[39:2]} + lh11;
    end
  end

  // stage 5: OFF and SENS
  logic [RAW_W-1:0]         s5_d1;
  logic signed [TEMP_W-1:0] s5_temp;
  region_t                  s5_region;
  logic signed [41:0]       s5_offs;
  logic signed [41:0]       s5_sens;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_d1     <= s4_d1;
      s5_temp   <= s4_temp;
      s5_region <= s4_region;
      s5_offs   <= 42'(s4_off_base) - $signed({1'b0, s4_corr_off});
      s5_sens   <= 42'(s4_sens_base) - $signed({1'b0, s4_corr_sens});
    end
  end

  // stage 6: D1 times SENS as high and low partial products
  logic signed [TEMP_W-1:0] s6_temp;
  region_t                  s6_region;
  logic signed [41:0]       s6_offs;
  logic signed [45:0]       s6_p_hi;
  logic [44:0]              s6_p_lo;
  logic signed [45:0]       p_hi_next;
  logic [44:0]              p_lo_next;

  assign p_hi_next = $signed({1'b0, s5_d1}) * $signed(s5_sens[41:21]);
  assign p_lo_next = s5_d1 * s5_sens[20:0];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_temp   <= s5_temp;
      s6_region <= s5_region;
      s6_offs   <= s5_offs;
      s6_p_hi   <= p_hi_next;
      s6_p_lo   <= p_lo_next;
    end
  end

  // stage 7: (D1*SENS >> 21) - OFF
  logic signed [TEMP_W-1:0] s7_temp;
  region_t                  s7_region;
  logic signed [47:0]       s7_acc;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_temp   <= s6_temp;
      s7_region <= s6_region;
      s7_acc    <= 48'(s6_p_hi) + $signed({24'b0, s6_p_lo[44:21]}) - 48'(s6_offs);
    end
  end

  // stage 8: output register, shift and clamp
  logic signed [TEMP_W-1:0]  s8_temp;
  region_t                   s8_region;
  logic signed [PRESS_W-1:0] s8_press;
  logic                      s8_sat;
  logic signed [32:0]        press_wide;
  logic                      press_ovf;

  assign press_wide = s7_acc[47:15];
  assign press_ovf  = press_wide[32] != press_wide[31];

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_temp   <= s7_temp;
      s8_region <= s7_region;
      s8_sat    <= press_ovf;
      if (press_ovf) begin
        s8_press <= press_wide[32] ? PRESS_MIN : PRESS_MAX;
      end else begin
        s8_press <= press_wide[31:0];
      end
    end
  end

  assign result.valid               = vld[NSTG-1];
  assign result.temperature_centi   = s8_temp;
  assign result.pressure_centi      = s8_press;
  assign result.compensation_region = s8_region;
  assign result.pressure_saturated  = s8_sat;

endmodule

// ----- sv/bpc_checker.sv -----
// Port-level checker for the barometric pressure compensation core, with its bind.
// Watches the result channel over time; depends on bpc_pkg.
module bpc_port_checker import bpc_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [TEMP_W-1:0]  temp,
  input logic signed [PRESS_W-1:0] press,
  input logic [1:0]                region,
  input logic                      sat
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temp) && $stable(press)
      && $stable(region) && $stable(sat))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && sat |-> press == PRESS_MAX || press == PRESS_MIN)
    else $error("saturation flag without clamped pressure");

  a_normal_temp: assert property (@(posedge clk) disable iff (rst)
    out_valid && region == REGION_NORMAL |-> temp >= TEMP_REF)
    else $error("normal region below reference temperature");

  a_vlow_temp: assert property (@(posedge clk) disable iff (rst)
    out_valid && region == REGION_VLOW |-> temp < TEMP_VLOW)
    else $error("very low region above its threshold");

endmodule

bind barometric_pressure_compensation_core bpc_port_checker u_bpc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .temp      (result.temperature_centi),
  .press     (result.pressure_centi),
  .region    (result.compensation_region),
  .sat       (result.pressure_saturated)
);
